### src/uart_8n1_transceiver_defines.svh
// Assertion helpers shared by the transceiver modules.
`ifndef UART_8N1_TRANSCEIVER_DEFINES_SVH
`define UART_8N1_TRANSCEIVER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UART8N1_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uart8n1: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define UART8N1_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uart8n1: next-cycle check failed");

`endif

### src/uart8n1_pkg.sv
package uart8n1_pkg;

  localparam int TicksW = 16;

  typedef logic [TicksW-1:0] ticks_t;

  localparam ticks_t TicksPerBitReset = 16'd16;
  localparam ticks_t CountMax         = '1;
  localparam logic [2:0] LastDataBit  = 3'd7;

  typedef struct packed {
    logic       done;
    logic       err;
    logic [7:0] data;
  } rx_status_t;

  typedef struct packed {
    logic line;
    logic idle;
  } tx_status_t;

  // Tick counters stop at their maximum rather than wrapping.
  function automatic ticks_t count_inc(ticks_t c);
    return (c == CountMax) ? c : c + ticks_t'(1);
  endfunction

endpackage

### src/uart8n1_if.sv
interface uart8n1_tick_if;
  logic       valid;
  logic       ready;
  logic       rx_line;
  logic       send_request;
  logic [7:0] send_byte;

  modport source (output valid, output rx_line, output send_request, output send_byte,
                  input ready);
  modport sink (input valid, input rx_line, input send_request, input send_byte,
                output ready);
endinterface

interface uart8n1_result_if;
  logic       valid;
  logic       ready;
  logic       tx_line;
  logic       tx_idle;
  logic       rx_done;
  logic [7:0] rx_byte;
  logic       rx_error;

  modport source (output valid, output tx_line, output tx_idle, output rx_done,
                  output rx_byte, output rx_error, input ready);
  modport sink (input valid, input tx_line, input tx_idle, input rx_done,
                input rx_byte, input rx_error, output ready);
endinterface

### src/uart8n1_rx.sv
module uart8n1_rx (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  logic                    line,
  input  uart8n1_pkg::ticks_t     ticks_per_bit,
  output uart8n1_pkg::rx_status_t status
);
  import uart8n1_pkg::*;

  typedef enum logic [3:0] {
    RX_WAIT  = 4'b0001,
    RX_START = 4'b0010,
    RX_DATA  = 4'b0100,
    RX_STOP  = 4'b1000
  } rx_state_t;

  rx_state_t  state, state_next;
  ticks_t     count, count_next;
  logic [7:0] shift, shift_next;
  logic [2:0] bit_idx, bit_idx_next;

  logic [TicksW:0] sample_sum;
  ticks_t          sample_tick;
  ticks_t          count_step;
  logic            at_sample;
  logic            at_end;
  logic            done;
  logic            err;

  // The sample point is half a bit period, rounded up.
  assign sample_sum  = {1'b0, ticks_per_bit} + {{TicksW{1'b0}}, 1'b1};
  assign sample_tick = sample_sum[TicksW:1];
  assign count_step  = count_inc(count);
  assign at_sample   = (count_step == sample_tick);
  assign at_end      = (count_step >= ticks_per_bit);

  always_comb begin
    state_next   = state;
    count_next   = count_step;
    shift_next   = shift;
    bit_idx_next = bit_idx;
    done         = 1'b0;
    err          = 1'b0;
    unique case (state)
      RX_WAIT: begin
        if (!line) begin
          state_next = RX_START;
          count_next = '0;
          shift_next = '0;
        end
      end
      RX_START: begin
        if (at_sample) begin
          if (line) begin
            state_next = RX_WAIT;
            err        = 1'b1;
          end
        end else if (at_end) begin
          state_next   = RX_DATA;
          bit_idx_next = '0;
          count_next   = '0;
        end
      end
      RX_DATA: begin
        if (at_sample) begin
          shift_next = {line, shift[7:1]};
        end else if (at_end) begin
          count_next = '0;
          if (bit_idx == LastDataBit) begin
            state_next = RX_STOP;
          end else begin
            bit_idx_next = bit_idx + 3'd1;
          end
        end
      end
      RX_STOP: begin
        if (at_sample) begin
          if (!line) begin
            shift_next = '0;
            state_next = RX_WAIT;
            err        = 1'b1;
          end
        end else if (at_end) begin
          state_next = RX_WAIT;
          count_next = '0;
          done       = 1'b1;
        end
      end
      default: begin
        state_next = RX_WAIT;
      end
    endcase
  end

  assign status = '{done: done, err: err, data: shift_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= RX_WAIT;
      count   <= '0;
      shift   <= '0;
      bit_idx <= '0;
    end else if (advance) begin
      state   <= state_next;
      count   <= count_next;
      shift   <= shift_next;
      bit_idx <= bit_idx_next;
    end
  end

endmodule

### src/uart8n1_tx.sv
`include "uart_8n1_transceiver_defines.svh"

module uart8n1_tx (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  logic                    send_request,
  input  logic [7:0]              send_byte,
  input  uart8n1_pkg::ticks_t     ticks_per_bit,
  output uart8n1_pkg::tx_status_t status
);
  import uart8n1_pkg::*;

  typedef enum logic [3:0] {
    TX_WAIT  = 4'b0001,
    TX_START = 4'b0010,
    TX_DATA  = 4'b0100,
    TX_STOP  = 4'b1000
  } tx_state_t;

  tx_state_t  state, state_next;
  ticks_t     count, count_next;
  logic [7:0] shift, shift_next;
  logic [2:0] bit_idx, bit_idx_next;
  logic       level, level_next;

  tx_state_t  state_now;
  logic [7:0] shift_now;
  ticks_t     count_step;
  logic       at_end;

  // A request restarts the frame in the same tick; its count starts from zero, as after
  // every bit boundary, so the start bit lasts as long as the others.
  assign state_now  = send_request ? TX_START : state;
  assign shift_now  = send_request ? send_byte : shift;
  assign count_step = send_request ? '0 : count_inc(count);
  assign at_end     = (count_step >= ticks_per_bit);

  always_comb begin
    state_next   = state_now;
    count_next   = count_step;
    shift_next   = shift_now;
    bit_idx_next = bit_idx;
    level_next   = level;
    unique case (state_now)
      TX_WAIT: begin
        level_next = 1'b1;
      end
      TX_START: begin
        if (at_end) begin
          state_next   = TX_DATA;
          bit_idx_next = '0;
          count_next   = '0;
          level_next   = shift_now[0];
        end else begin
          level_next = 1'b0;
        end
      end
      TX_DATA: begin
        if (at_end) begin
          count_next = '0;
          if (bit_idx == LastDataBit) begin
            state_next = TX_STOP;
            level_next = 1'b1;
          end else begin
            bit_idx_next = bit_idx + 3'd1;
            shift_next   = {1'b0, shift_now[7:1]};
            level_next   = shift_now[1];
          end
        end
      end
      TX_STOP: begin
        if (at_end) begin
          state_next = TX_WAIT;
          count_next = '0;
        end
        level_next = 1'b1;
      end
      default: begin
        state_next = TX_WAIT;
      end
    endcase
  end

  assign status = '{line: level_next, idle: (state_next == TX_WAIT)};

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= TX_WAIT;
      count   <= '0;
      shift   <= '0;
      bit_idx <= '0;
      level   <= 1'b1;
    end else if (advance) begin
      state   <= state_next;
      count   <= count_next;
      shift   <= shift_next;
      bit_idx <= bit_idx_next;
      level   <= level_next;
    end
  end

  `UART8N1_ASSERT_IMP(a_idle_line_high, clk, rst, state == TX_WAIT, level)
  `UART8N1_ASSERT_IMP(a_start_line_low, clk, rst, state == TX_START, !level)

endmodule

### src/uart_8n1_transceiver.sv
// UART 8N1 transceiver: one transaction on the tick channel is one clock tick of the line.
// A tick is held in the input register and then in the result register before its
// result is offered; it waits in the input register while the result register is full.
// Throughput: one tick per cycle while res_ch is ready; tick_ch.ready follows res_ch.ready.
// Reset (synchronous, active high): both framers wait with the tx line high, counters
// and shift registers clear, ticks_per_bit returns to 16, both pipeline registers empty.
`include "uart_8n1_transceiver_defines.svh"

module uart_8n1_transceiver (
  input  logic                          clk,
  input  logic                          rst,
  uart8n1_tick_if.sink                  tick_ch,
  uart8n1_result_if.source              res_ch,
  input  logic                          cfg_we,
  input  logic [uart8n1_pkg::TicksW-1:0] cfg_wdata
);
  import uart8n1_pkg::*;

  ticks_t     ticks_per_bit;

  logic       in_valid;
  logic       in_rx_line;
  logic       in_send_request;
  logic [7:0] in_send_byte;

  logic       out_valid;
  logic       out_tx_line;
  logic       out_tx_idle;
  logic       out_rx_done;
  logic [7:0] out_rx_byte;
  logic       out_rx_error;

  logic       advance;
  rx_status_t rx_status;
  tx_status_t tx_status;

  assign advance       = in_valid && (!out_valid || res_ch.ready);
  assign tick_ch.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_bit <= TicksPerBitReset;
    end else if (cfg_we) begin
      ticks_per_bit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick_ch.ready) begin
      in_valid <= tick_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_ch.valid && tick_ch.ready) begin
      in_rx_line      <= tick_ch.rx_line;
      in_send_request <= tick_ch.send_request;
      in_send_byte    <= tick_ch.send_byte;
    end
  end

  uart8n1_rx u_rx (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .line          (in_rx_line),
    .ticks_per_bit (ticks_per_bit),
    .status        (rx_status)
  );

  uart8n1_tx u_tx (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .send_request  (in_send_request),
    .send_byte     (in_send_byte),
    .ticks_per_bit (ticks_per_bit),
    .status        (tx_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_tx_line  <= tx_status.line;
      out_tx_idle  <= tx_status.idle;
      out_rx_done  <= rx_status.done;
      out_rx_byte  <= rx_status.data;
      out_rx_error <= rx_status.err;
    end
  end

  assign res_ch.valid    = out_valid;
  assign res_ch.tx_line  = out_tx_line;
  assign res_ch.tx_idle  = out_tx_idle;
  assign res_ch.rx_done  = out_rx_done;
  assign res_ch.rx_byte  = out_rx_byte;
  assign res_ch.rx_error = out_rx_error;

  `UART8N1_ASSERT_NEXT(a_advance_fills_result, clk, rst, advance, out_valid)
  `UART8N1_ASSERT_IMP(a_done_excludes_error, clk, rst, out_valid, !(out_rx_done && out_rx_error))
  `UART8N1_ASSERT_IMP(a_stall_only_when_full, clk, rst, !tick_ch.ready, in_valid && out_valid && !res_ch.ready)

endmodule
